### hw/rtl/srfc_pkg.sv
// Package for the sensor response frame checker: status codes, frame constants,
// the result word type and the byte-wide reflected CRC-16 update.
// No dependencies.
package srfc_pkg;

   // Frame constants
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  READ_CODE  = 8'h03;
   localparam logic [3:0]  MAX_COUNT  = 4'd10;
   localparam logic [3:0]  COUNT_RESET = 4'd4;
   localparam int          DATA_KEEP  = 4;

   // Frame status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [1:0] STATUS_HDR_ERR = 2'd2;

   // One result word handed from the frame core to the output stage.
   typedef struct packed {
      logic               valid;
      logic [1:0]         frame_status;
      logic [15:0]        humidity_tenths;
      logic signed [15:0] temperature_tenths;
   } srfc_result_type;

   // Reflected CRC-16 over one byte, LSB first, eight shift steps.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                            input logic [7:0] data_byte);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

### hw/rtl/srfc_req_if.sv
// Input channel of the frame checker: one received response byte per word.
// Depends on nothing.
interface srfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

### hw/rtl/srfc_rsp_if.sv
// Result channel of the frame checker: status and sensor values per word.
// Depends on nothing.
interface srfc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         frame_status;
   logic [15:0]        humidity_tenths;
   logic signed [15:0] temperature_tenths;

   modport source (output valid, output frame_status, output humidity_tenths,
                   output temperature_tenths, input ready);
   modport sink   (input valid, input frame_status, input humidity_tenths,
                   input temperature_tenths, output ready);
endinterface

### hw/rtl/sensor_response_frame_checker_top.sv
// Top level of the sensor response frame checker.
// Depends on srfc_pkg, srfc_req_if, srfc_rsp_if, srfc_frame_core, srfc_out_stage.
//
// Usage:
//   req_channel carries one response byte per word with a frame_start flag on
//   the first byte of a frame. The frame is function code, byte count, the
//   data bytes and the CRC-16 low byte then high byte.
//   rsp_channel carries one word per completed frame: status (ok, CRC error,
//   header error), humidity and signed temperature in tenths.
//   csr_write_enable/csr_write_data set the expected data byte count while
//   the block is idle; values above ten act as ten.
// Latency and throughput:
//   One byte is accepted per cycle unless a stalled result holds the input.
//   The result word appears on rsp_channel in the cycle after the frame's last
//   byte is accepted; the byte-wide CRC update feeds the frame state registers.
// Reset:
//   Clears the frame state as if a frame were starting and sets the count to 4.
// Stalls:
//   While a result waits and rsp_channel.ready is low, req_channel.ready is low.
//   A waiting result that is taken in the same cycle lets the next byte in.
module sensor_response_frame_checker_top (
   input  logic       clock,
   input  logic       reset,
   srfc_req_if.sink   req_channel,
   srfc_rsp_if.source rsp_channel,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data
);
   import srfc_pkg::*;

   logic [3:0]      count_ff;
   logic            can_accept;
   logic            accept;
   srfc_result_type result;

   // Byte count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   assign req_channel.ready = can_accept;
   assign accept            = req_channel.valid && can_accept;

   // Frame tracking.
   srfc_frame_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .rx_byte        (req_channel.rx_byte),
      .frame_start    (req_channel.frame_start),
      .register_count (count_ff),
      .result         (result)
   );

   // Result register.
   srfc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .can_accept (can_accept),
      .rsp        (rsp_channel)
   );

   // A failed frame reports zero sensor values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && rsp_channel.frame_status != STATUS_OK |->
      rsp_channel.humidity_tenths == 16'h0000 &&
      rsp_channel.temperature_tenths == 16'sh0000)
      else $error("error result carries nonzero data");

   // A stalled result blocks the input side.
   assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && !rsp_channel.ready |-> !req_channel.ready)
      else $error("input accepted while result is stalled");

   // A new result only follows an accepted byte.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_channel.valid) |-> $past(req_channel.valid && req_channel.ready))
      else $error("result appeared without an accepted byte");

endmodule

### hw/rtl/srfc_frame_core.sv
// Frame tracking for the checker: byte position, running CRC, header check
// and captured data bytes. Depends on srfc_pkg.
module srfc_frame_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               rx_byte,
   input  logic                     frame_start,
   input  logic [3:0]               register_count,
   output srfc_pkg::srfc_result_type result
);
   import srfc_pkg::*;

   logic [3:0]  byte_position_ff, byte_position_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic        header_ok_ff, header_ok_in;
   logic [7:0]  captured_data_ff [DATA_KEEP];
   logic [7:0]  captured_data_in [DATA_KEEP];
   logic [7:0]  crc_low_byte_ff, crc_low_byte_in;

   logic [3:0]  count;
   logic [4:0]  pos;
   logic [4:0]  data_end;
   logic [15:0] base_crc;
   logic        base_hok;
   logic [7:0]  base_data [DATA_KEEP];
   logic [7:0]  base_low;
   logic [15:0] got_crc;
   logic [1:0]  status;

   // Effective data byte count, values above ten act as ten.
   assign count    = (register_count > MAX_COUNT) ? MAX_COUNT : register_count;
   assign data_end = {1'b0, count} + 5'd2;

   // Next frame state for the accepted byte.
   always_comb begin
      pos      = frame_start ? 5'd0 : {1'b0, byte_position_ff};
      base_crc = frame_start ? CRC_INIT : running_crc_ff;
      base_hok = frame_start ? 1'b1 : header_ok_ff;
      base_low = frame_start ? 8'h00 : crc_low_byte_ff;
      for (int i = 0; i < DATA_KEEP; i++) begin
         base_data[i] = frame_start ? 8'h00 : captured_data_ff[i];
      end

      byte_position_in = pos[3:0];
      running_crc_in   = base_crc;
      header_ok_in     = base_hok;
      crc_low_byte_in  = base_low;
      captured_data_in = base_data;
      got_crc          = {rx_byte, base_low};
      status           = STATUS_OK;
      result           = '0;

      if (pos < data_end) begin
         // Header and data bytes enter the CRC.
         if (pos == 5'd0) begin
            header_ok_in = (rx_byte == READ_CODE);
         end else if (pos == 5'd1) begin
            header_ok_in = base_hok & (rx_byte == {4'h0, count});
         end
         for (int i = 0; i < DATA_KEEP; i++) begin
            if (pos == 5'(i + 2)) begin
               captured_data_in[i] = rx_byte;
            end
         end
         running_crc_in   = crc_feed(base_crc, rx_byte);
         byte_position_in = 4'(pos + 5'd1);
      end else if (pos == data_end) begin
         // CRC low byte arrives first.
         crc_low_byte_in  = rx_byte;
         byte_position_in = 4'(pos + 5'd1);
      end else if (pos == data_end + 5'd1) begin
         // Last byte: CRC check first, then the header.
         if (base_crc != got_crc) begin
            status = STATUS_CRC_ERR;
         end else if (!base_hok) begin
            status = STATUS_HDR_ERR;
         end
         byte_position_in    = 4'(pos + 5'd1);
         result.valid        = accept;
         result.frame_status = status;
         if (status == STATUS_OK) begin
            result.humidity_tenths    = {base_data[0], base_data[1]};
            result.temperature_tenths = {base_data[2], base_data[3]};
         end
      end
   end

   // Frame state registers, updated on every accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         running_crc_ff   <= CRC_INIT;
         header_ok_ff     <= 1'b1;
         crc_low_byte_ff  <= '0;
         for (int i = 0; i < DATA_KEEP; i++) begin
            captured_data_ff[i] <= '0;
         end
      end else if (accept) begin
         byte_position_ff <= byte_position_in;
         running_crc_ff   <= running_crc_in;
         header_ok_ff     <= header_ok_in;
         crc_low_byte_ff  <= crc_low_byte_in;
         captured_data_ff <= captured_data_in;
      end
   end

endmodule

### hw/rtl/srfc_out_stage.sv
// Output register of the frame checker; holds one result word until taken.
// Depends on srfc_pkg and srfc_rsp_if.
module srfc_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  srfc_pkg::srfc_result_type result,
   output logic                      can_accept,
   srfc_rsp_if.source                rsp
);
   import srfc_pkg::*;

   logic               valid_ff, valid_in;
   logic [1:0]         status_ff;
   logic [15:0]        humidity_ff;
   logic signed [15:0] temperature_ff;

   // A new byte may enter when the register is empty or is being drained.
   assign can_accept = !valid_ff || rsp.ready;
   assign valid_in   = result.valid || (valid_ff && !rsp.ready);

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, loaded only with a fresh result.
   always_ff @(posedge clock) begin
      if (result.valid) begin
         status_ff      <= result.frame_status;
         humidity_ff    <= result.humidity_tenths;
         temperature_ff <= result.temperature_tenths;
      end
   end

   assign rsp.valid              = valid_ff;
   assign rsp.frame_status       = status_ff;
   assign rsp.humidity_tenths    = humidity_ff;
   assign rsp.temperature_tenths = temperature_ff;

endmodule

### bench/srfc_frame_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the sensor response frame checker: watches the byte and result
// channels and the count register port, predicts each result word and compares it.
// Depends on srfc_pkg, srfc_req_if and srfc_rsp_if.
module srfc_frame_scoreboard (
   input  logic       clock,
   input  logic       reset,
   srfc_req_if        req_mon,
   srfc_rsp_if        rsp_mon,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data,
   output int         fail_count,
   output int         pending_count
);
   import srfc_pkg::*;

   typedef struct {
      logic [1:0]         status;
      logic [15:0]        humidity;
      logic signed [15:0] temperature;
   } sensor_reading_type;

   // Predicted frame state, kept apart from the block.
   logic [3:0]         count_reg;
   logic [3:0]         position;
   logic [15:0]        crc_acc;
   logic               hdr_good;
   logic [7:0]         kept [4];
   logic [7:0]         crc_lo;
   sensor_reading_type readings_due [$];

   // Reflected CRC-16, one bit per step, low bit of the byte first.
   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         r = {1'b0, r[15:1]} ^ ((r[0] ^ b[i]) ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic void restart_frame();
      position = 4'd0;
      crc_acc  = CRC_INIT;
      hdr_good = 1'b1;
      crc_lo   = 8'h00;
      for (int i = 0; i < 4; i++) kept[i] = 8'h00;
   endfunction

   // Advance the predicted frame by one received word; queue a reading at the
   // frame's last byte.
   function automatic void take_byte(input logic [7:0] b, input logic start);
      int                 span;
      int                 pos;
      logic [15:0]        got;
      sensor_reading_type r;
      span = (count_reg > MAX_COUNT) ? int'(MAX_COUNT) : int'(count_reg);
      if (start) restart_frame();
      pos = int'(position);
      if (pos >= span + 4) return;
      if (pos < span + 2) begin
         if (pos == 0) begin
            hdr_good = (b == READ_CODE);
         end else if (pos == 1) begin
            hdr_good = hdr_good & (int'(b) == span);
         end else if (pos - 2 < 4) begin
            kept[pos - 2] = b;
         end
         crc_acc = crc_step(crc_acc, b);
      end else if (pos == span + 2) begin
         crc_lo = b;
      end else begin
         got = {b, crc_lo};
         if (got != crc_acc) begin
            r.status = STATUS_CRC_ERR;
         end else if (!hdr_good) begin
            r.status = STATUS_HDR_ERR;
         end else begin
            r.status = STATUS_OK;
         end
         if (r.status == STATUS_OK) begin
            r.humidity    = {kept[0], kept[1]};
            r.temperature = {kept[2], kept[3]};
         end else begin
            r.humidity    = 16'h0000;
            r.temperature = 16'sh0000;
         end
         readings_due.push_back(r);
      end
      position = 4'(pos + 1);
   endfunction

   // One printed line per mismatch; printing stops after a hundred.
   task automatic report_mismatch(input string msg);
      if (fail_count < 100) $display("%0t scoreboard: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_reading();
      sensor_reading_type want;
      if (readings_due.size() == 0) begin
         report_mismatch("result word with no frame waiting");
         return;
      end
      want = readings_due.pop_front();
      if (rsp_mon.frame_status !== want.status)
         report_mismatch($sformatf("frame_status %0d, expected %0d",
                                   rsp_mon.frame_status, want.status));
      if (rsp_mon.humidity_tenths !== want.humidity)
         report_mismatch($sformatf("humidity_tenths %0d, expected %0d",
                                   rsp_mon.humidity_tenths, want.humidity));
      if (rsp_mon.temperature_tenths !== want.temperature)
         report_mismatch($sformatf("temperature_tenths %0d, expected %0d",
                                   rsp_mon.temperature_tenths, want.temperature));
   endtask

   // Results are compared before the byte of the same edge is taken, since a
   // byte's result is registered and so cannot appear at its own edge. A count written
   // at the same edge applies from the next byte on.
   always @(posedge clock) begin
      if (reset) begin
         count_reg = COUNT_RESET;
         restart_frame();
         readings_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_reading();
         if (req_mon.valid && req_mon.ready) take_byte(req_mon.rx_byte, req_mon.frame_start);
         if (csr_write_enable) count_reg = csr_write_data;
      end
      pending_count <= readings_due.size();
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the frame checker testbench: clock, reset, byte and count stimulus,
// result-side stalls and the verdict. Depends on srfc_pkg, both channel
// interfaces, the block's top level and srfc_frame_scoreboard.
module tb_top;
   import srfc_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_BYTES = 1550;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [3:0] csr_write_data;
   int         fail_count;
   int         pending_count;
   int         cycle_count;
   int         bytes_sent;
   logic       quiet;
   logic [3:0] cur_count;
   logic [7:0] data_bytes [10];
   logic [3:0] first_counts [7] = '{4'd15, 4'd1, 4'd2, 4'd10, 4'd0, 4'd3, 4'd11};

   srfc_req_if req_bus();
   srfc_rsp_if rsp_bus();

   sensor_response_frame_checker_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   srfc_frame_scoreboard scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[sensor_response_frame_checker_top] ERROR");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int count_span();
      return (cur_count > MAX_COUNT) ? int'(MAX_COUNT) : int'(cur_count);
   endfunction

   // Result side: random stalls of random length.
   initial begin : sink_pacing
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) hold = pick_gap();
         end
      end
   end

   // Offer one word and wait for it to be taken.
   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.rx_byte     <= b;
      req_bus.frame_start <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Hold the sender until every expected result has come, plus the output latency.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_count(input logic [3:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_count = value;
   endtask

   // Data bytes lean toward the sign and range edges.
   task automatic fill_data();
      for (int i = 0; i < 10; i++) begin
         case ($urandom_range(0, 9))
            0: data_bytes[i] = 8'h00;
            1: data_bytes[i] = 8'hFF;
            2: data_bytes[i] = 8'h80;
            3: data_bytes[i] = 8'h7F;
            default: data_bytes[i] = 8'($urandom_range(0, 255));
         endcase
      end
   endtask

   // Build a response frame from data_bytes and send its first stop_after bytes.
   task automatic send_frame(input int n, input logic [7:0] code, input logic [7:0] count_byte,
                             input logic [15:0] crc_mask, input logic lead_start,
                             input int stop_after);
      logic [7:0]  wire_bytes [14];
      logic [15:0] crc;
      wire_bytes[0] = code;
      wire_bytes[1] = count_byte;
      for (int i = 0; i < n; i++) wire_bytes[i + 2] = data_bytes[i];
      crc = CRC_INIT;
      for (int i = 0; i < n + 2; i++) crc = crc_feed(crc, wire_bytes[i]);
      crc ^= crc_mask;
      wire_bytes[n + 2] = crc[7:0];
      wire_bytes[n + 3] = crc[15:8];
      for (int i = 0; i < stop_after; i++)
         send_byte(wire_bytes[i], (i == 0) ? lead_start : 1'b0);
   endtask

   // Mostly well-formed frames, the rest corrupted, cut short, trailed or noise.
   task automatic send_random_frame();
      int          n;
      int          kind;
      int          stop;
      int          trail;
      logic [7:0]  code;
      logic [7:0]  cnt;
      logic [15:0] mask;
      n     = count_span();
      kind  = $urandom_range(0, 99);
      code  = READ_CODE;
      cnt   = 8'(n);
      mask  = 16'h0000;
      stop  = n + 4;
      trail = 0;
      fill_data();
      if (kind >= 90) begin
         // Random bytes with an occasional frame start.
         repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         return;
      end
      if (kind >= 62 && kind < 72) begin
         mask = 16'($urandom_range(1, 65535));
      end else if (kind >= 72 && kind < 77) begin
         code = 8'($urandom_range(0, 255));
         if (code == READ_CODE) code = ~code;
      end else if (kind >= 77 && kind < 82) begin
         cnt = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
         if (cnt == 8'(n)) cnt ^= 8'h10;
      end else if (kind >= 82 && kind < 86) begin
         stop = $urandom_range(1, n + 3);
      end else if (kind >= 86) begin
         trail = $urandom_range(1, 3);
      end
      send_frame(n, code, cnt, mask, 1'b1, stop);
      repeat (trail) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   initial begin : stimulus
      int         phase_idx;
      int         phase_end;
      logic [3:0] next_count;
      reset               = 1'b1;
      quiet               = 1'b0;
      cur_count           = COUNT_RESET;
      csr_write_enable    = 1'b0;
      csr_write_data      = 4'd0;
      req_bus.valid       = 1'b0;
      req_bus.rx_byte     = 8'h00;
      req_bus.frame_start = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a frame with no start flag right after reset, carrying the
      // largest humidity and the most negative temperature.
      data_bytes[0] = 8'hFF;
      data_bytes[1] = 8'hFF;
      data_bytes[2] = 8'h80;
      data_bytes[3] = 8'h00;
      send_frame(4, READ_CODE, 8'd4, 16'h0000, 1'b0, 8);
      // A byte after the frame's end is ignored.
      send_byte(8'hFF, 1'b0);
      // Zero data bytes: a cut frame restarted, then good, bad code and bad CRC.
      write_count(4'd0);
      send_frame(0, READ_CODE, 8'd0, 16'h0000, 1'b1, 2);
      send_frame(0, READ_CODE, 8'd0, 16'h0000, 1'b1, 4);
      send_frame(0, 8'h04, 8'd0, 16'h0000, 1'b1, 4);
      send_frame(0, READ_CODE, 8'd0, 16'h0100, 1'b1, 4);

      // Random phases, each with its own count; some run without any idling.
      phase_idx = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         next_count = (phase_idx < 7) ? first_counts[phase_idx] : 4'($urandom_range(0, 15));
         write_count(next_count);
         quiet = (phase_idx % 4 == 2);
         // Sometimes carry on a frame cut short before the count changed.
         if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         phase_end = bytes_sent + $urandom_range(60, 200);
         if (phase_end > RANDOM_BYTES) phase_end = RANDOM_BYTES;
         while (bytes_sent < phase_end) begin
            send_random_frame();
            if ($urandom_range(0, 39) == 0) wait_idle();
         end
         // Leave a frame unfinished across the next count change now and then.
         if ($urandom_range(0, 2) == 0) begin
            fill_data();
            send_frame(count_span(), READ_CODE, 8'(count_span()), 16'h0000, 1'b1,
                       $urandom_range(1, count_span() + 3));
         end
         phase_idx++;
      end

      quiet = 1'b0;
      wait_idle();
      repeat (5) @(posedge clock);
      if (fail_count == 0) begin
         $display("[sensor_response_frame_checker_top] OK");
      end else begin
         $display("[sensor_response_frame_checker_top] ERROR");
      end
      $finish;
   end

endmodule
